@@ hdl/rlt_pkg.sv @@
package rlt_pkg;

  // Character codes the tokenizer reacts to
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_HASH  = 8'd35;
  localparam logic [7:0] CH_OPEN  = 8'd123;
  localparam logic [7:0] CH_CLOSE = 8'd125;
  localparam logic [7:0] CH_A     = 8'd65;
  localparam logic [7:0] CH_Z     = 8'd90;

  // Parse phase of the current line
  typedef enum logic [2:0] {
    PH_LINE  = 3'd0,
    PH_LABEL = 3'd1,
    PH_GAP   = 3'd2,
    PH_BARE  = 3'd3,
    PH_QUOTE = 3'd4
  } phase_t;

  // Error codes reported with each word
  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_LINE_START = 2'd1,
    ERR_LABEL_CHAR = 2'd2
  } err_t;

  // One result word
  typedef struct packed {
    logic [7:0] byte_out;
    logic       appended;
    logic       token_end;
    logic       record_end;
    logic       in_sub_entry;
    err_t       error_code;
  } rlt_result_t;

  // Space or tab
  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // Upper-case letter
  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

endpackage

@@ hdl/rlt_in_stage.sv @@
module rlt_in_stage
  import rlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       load;

  // Stall only while a held word cannot move on
  assign in_stall = valid_r && !advance;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_byte_in;
    end
  end

  assign held_valid = valid_r;
  assign held_byte  = byte_r;

endmodule

@@ hdl/rlt_parser.sv @@
module rlt_parser
  import rlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic [7:0]  byte_in,
  output rlt_result_t result
);

  phase_t phase_r;
  phase_t phase_nxt;
  logic   sub_r;
  logic   sub_nxt;

  // Next phase and sub-entry flag
  always_comb begin
    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    case (phase_r)
      PH_LABEL: begin
        if (is_upper(byte_in)) begin
          phase_nxt = PH_LABEL;
        end else if (is_white(byte_in) || byte_in == CH_CR) begin
          phase_nxt = PH_GAP;
        end else begin
          phase_nxt = PH_LINE;
        end
      end
      PH_GAP: begin
        if (is_white(byte_in) || byte_in == CH_CR) begin
          phase_nxt = PH_GAP;
        end else if (byte_in == CH_LF) begin
          phase_nxt = PH_LINE;
        end else if (byte_in == CH_QUOTE) begin
          phase_nxt = PH_QUOTE;
        end else begin
          phase_nxt = PH_BARE;
        end
      end
      PH_BARE: begin
        if (is_white(byte_in)) begin
          phase_nxt = PH_GAP;
        end else if (byte_in == CH_LF) begin
          phase_nxt = PH_LINE;
        end
      end
      PH_QUOTE: begin
        if (byte_in == CH_QUOTE) begin
          phase_nxt = PH_GAP;
        end
      end
      default: begin
        phase_nxt = PH_LINE;
        if (byte_in == CH_LF || byte_in == CH_CR) begin
          phase_nxt = PH_LINE;
        end else if (byte_in == CH_HASH) begin
          phase_nxt = PH_LABEL;
        end else if (byte_in == CH_OPEN && !sub_r) begin
          sub_nxt = 1'b1;
        end else if (sub_r && is_white(byte_in)) begin
          sub_nxt = 1'b1;
        end else if (byte_in == CH_CLOSE && sub_r) begin
          sub_nxt = 1'b0;
        end
      end
    endcase
  end

  // Per-word flags
  always_comb begin
    result              = '0;
    result.byte_out     = byte_in;
    result.in_sub_entry = sub_nxt;
    result.error_code   = ERR_NONE;
    case (phase_r)
      PH_LABEL: begin
        if (is_upper(byte_in)) begin
          result.appended = 1'b1;
        end else if (is_white(byte_in) || byte_in == CH_CR) begin
          result.token_end = 1'b1;
        end else if (byte_in == CH_LF) begin
          result.token_end  = 1'b1;
          result.record_end = 1'b1;
        end else begin
          // drop the partial label
          result.error_code = ERR_LABEL_CHAR;
        end
      end
      PH_GAP: begin
        if (is_white(byte_in) || byte_in == CH_CR) begin
          result.appended = 1'b0;
        end else if (byte_in == CH_LF) begin
          result.record_end = 1'b1;
        end else if (byte_in != CH_QUOTE) begin
          result.appended = 1'b1;
        end
      end
      PH_BARE: begin
        if (is_white(byte_in)) begin
          result.token_end = 1'b1;
        end else if (byte_in == CH_LF) begin
          result.token_end  = 1'b1;
          result.record_end = 1'b1;
        end else if (byte_in != CH_CR) begin
          result.appended = 1'b1;
        end
      end
      PH_QUOTE: begin
        if (byte_in == CH_QUOTE) begin
          result.token_end = 1'b1;
        end else begin
          result.appended = 1'b1;
        end
      end
      default: begin
        if (byte_in == CH_LF || byte_in == CH_CR) begin
          result.appended = 1'b0;
        end else if (byte_in == CH_HASH) begin
          result.appended = 1'b1;
        end else if (byte_in == CH_OPEN && !sub_r) begin
          result.appended = 1'b0;
        end else if (sub_r && is_white(byte_in)) begin
          result.appended = 1'b0;
        end else if (byte_in == CH_CLOSE && sub_r) begin
          result.appended = 1'b0;
        end else begin
          result.error_code = ERR_LINE_START;
        end
      end
    endcase
  end

  // Advance the state once per word passed on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE;
      sub_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
    end
  end

endmodule

@@ hdl/rlt_out_stage.sv @@
module rlt_out_stage
  import rlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        held_valid,
  input  rlt_result_t result,
  output logic        advance,
  output logic        out_valid,
  input  logic        out_stall,
  output rlt_result_t out_word
);

  logic        valid_r;
  logic        valid_nxt;
  rlt_result_t word_r;

  // Move a word in when the register is empty or being drained
  assign advance = held_valid && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

@@ hdl/record_line_tokenizer_top.sv @@
// Record line tokenizer: one text byte in, one flagged byte out.
// Input channel: in_valid / in_stall carry in_byte_in. A word is taken on
// a rising edge with in_valid high and in_stall low.
// Result channel: out_valid / out_stall carry the echoed byte, the append,
// token end and record end flags, the sub-entry flag and an error code.
// Each byte passes two register stages: an input register and a result
// register, with the phase decode between them.
// Throughput: one byte per clock while out_stall is low; the parse phase
// and sub-entry flag are updated as each byte moves on, so each byte sees
// the state its predecessor left.
// Reset (rst_n low, synchronous): both stages empty, phase at line start,
// sub-entry flag clear.
// When out_stall is high the result word holds; the input register keeps
// one more byte, and in_stall rises once both are full.
module record_line_tokenizer_top
  import rlt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic       out_appended,
  output logic       out_token_end,
  output logic       out_record_end,
  output logic       out_in_sub_entry,
  output logic [1:0] out_error_code
);

  logic        advance;
  logic        held_valid;
  logic [7:0]  held_byte;
  rlt_result_t result;
  rlt_result_t out_word;

  rlt_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte_in (in_byte_in),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  rlt_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (held_byte),
    .result  (result)
  );

  rlt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .held_valid (held_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  assign out_byte_out     = out_word.byte_out;
  assign out_appended     = out_word.appended;
  assign out_token_end    = out_word.token_end;
  assign out_record_end   = out_word.record_end;
  assign out_in_sub_entry = out_word.in_sub_entry;
  assign out_error_code   = out_word.error_code;

  // A record only ends on a line feed
  a_rec_end_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_record_end |-> out_byte_out == CH_LF)
    else $error("record end on a byte other than line feed");

  // A byte never both joins and closes a token
  a_app_tend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_appended && out_token_end))
    else $error("byte both appended and closing a token");

  // An error word carries no token activity
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> !out_appended && !out_token_end
      && !out_record_end)
    else $error("error word with token flags set");

  // Input back-pressure only when the result word is stuck
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the result side is free");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps

module tb
  import rlt_pkg::*;
();

  localparam int QUIET_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;
  localparam int REPORT_MAX   = 10;
  localparam int HOLD_CYCLES  = 150;

  // Character ranges used to break labels
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_byte_in;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte_out;
  logic       out_appended;
  logic       out_token_end;
  logic       out_record_end;
  logic       out_in_sub_entry;
  logic [1:0] out_error_code;

  // Flagged bytes predicted for accepted input words, oldest first
  rlt_result_t flagged_bytes_q[$];

  // Tokenizer state as the predictor sees it
  phase_t parse_ph = PH_LINE;
  logic   sub_flag = 1'b0;

  int mismatch_count = 0;
  int tx_idle_pct    = 0;
  int rx_idle_pct    = 0;
  int hold_request   = 0;
  int bytes_sent     = 0;
  int quiet_cycles   = 0;

  record_line_tokenizer_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_out     (out_byte_out),
    .out_appended     (out_appended),
    .out_token_end    (out_token_end),
    .out_record_end   (out_record_end),
    .out_in_sub_entry (out_in_sub_entry),
    .out_error_code   (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the parse state by one byte and return the flagged byte
  function automatic rlt_result_t tokenize_byte(input logic [7:0] c);
    rlt_result_t r;
    logic        blank;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    r = '0;
    r.byte_out = c;
    r.error_code = ERR_NONE;
    case (parse_ph)
      PH_LABEL: begin
        if (c >= CH_A && c <= CH_Z) begin
          r.appended = 1'b1;
        end else if (blank || c == CH_CR) begin
          r.token_end = 1'b1;
          parse_ph = PH_GAP;
        end else if (c == CH_LF) begin
          r.token_end = 1'b1;
          r.record_end = 1'b1;
          parse_ph = PH_LINE;
        end else begin
          // drop the partial label
          r.error_code = ERR_LABEL_CHAR;
          parse_ph = PH_LINE;
        end
      end
      PH_GAP: begin
        if (blank || c == CH_CR) begin
        end else if (c == CH_LF) begin
          r.record_end = 1'b1;
          parse_ph = PH_LINE;
        end else if (c == CH_QUOTE) begin
          parse_ph = PH_QUOTE;
        end else begin
          r.appended = 1'b1;
          parse_ph = PH_BARE;
        end
      end
      PH_BARE: begin
        if (blank) begin
          r.token_end = 1'b1;
          parse_ph = PH_GAP;
        end else if (c == CH_LF) begin
          r.token_end = 1'b1;
          r.record_end = 1'b1;
          parse_ph = PH_LINE;
        end else if (c != CH_CR) begin
          r.appended = 1'b1;
        end
      end
      PH_QUOTE: begin
        if (c == CH_QUOTE) begin
          r.token_end = 1'b1;
          parse_ph = PH_GAP;
        end else begin
          r.appended = 1'b1;
        end
      end
      default: begin
        parse_ph = PH_LINE;
        if (c == CH_LF || c == CH_CR) begin
        end else if (c == CH_HASH) begin
          r.appended = 1'b1;
          parse_ph = PH_LABEL;
        end else if (c == CH_OPEN && !sub_flag) begin
          sub_flag = 1'b1;
        end else if (sub_flag && blank) begin
        end else if (c == CH_CLOSE && sub_flag) begin
          sub_flag = 1'b0;
        end else begin
          r.error_code = ERR_LINE_START;
        end
      end
    endcase
    r.in_sub_entry = sub_flag;
    return r;
  endfunction

  // Predict each accepted input word
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      flagged_bytes_q.insert(flagged_bytes_q.size(), tokenize_byte(in_byte_in));
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_result
    rlt_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (flagged_bytes_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected result word: byte=%02h with nothing pending", out_byte_out);
        end
      end else begin
        want = flagged_bytes_q.pop_front();
        if (out_byte_out !== want.byte_out || out_appended !== want.appended ||
            out_token_end !== want.token_end || out_record_end !== want.record_end ||
            out_in_sub_entry !== want.in_sub_entry || out_error_code !== want.error_code) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("mismatch: expected byte=%02h app=%0b tend=%0b rend=%0b sub=%0b err=%0d",
                     want.byte_out, want.appended, want.token_end, want.record_end,
                     want.in_sub_entry, want.error_code);
            $display("          actual   byte=%02h app=%0b tend=%0b rend=%0b sub=%0b err=%0d",
                     out_byte_out, out_appended, out_token_end, out_record_end,
                     out_in_sub_entry, out_error_code);
          end
        end
      end
    end
  end

  // End the run when neither channel moves a word for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Offer one byte, idling at random first; return at the next falling edge
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= b;
    bytes_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the sender until every predicted word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (flagged_bytes_q.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Close whatever is open and return to line start
  task automatic resync_line();
    while (parse_ph != PH_LINE) send_byte(parse_ph == PH_QUOTE ? CH_QUOTE : CH_LF);
  endtask

  function automatic logic [7:0] bare_char(input bit first);
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_LF ||
           (first && (c == CH_QUOTE || c == CH_CR)));
    return c;
  endfunction

  function automatic logic [7:0] quoted_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // Well-formed record: label, members bare or quoted, line feed
  task automatic send_record(input bit indented);
    int members;
    if (indented) repeat ($urandom_range(3, 1)) send_byte(blank_char());
    send_byte(CH_HASH);
    repeat ($urandom_range(8, 1)) send_byte(8'(CH_A + $urandom_range(25)));
    members = $urandom_range(4);
    repeat (members) begin
      send_byte(blank_char());
      if ($urandom_range(3) == 0) send_byte(CH_CR);
      if ($urandom_range(1)) begin
        send_byte(bare_char(1'b1));
        repeat ($urandom_range(5)) send_byte(bare_char(1'b0));
      end else begin
        send_byte(CH_QUOTE);
        repeat ($urandom_range(6)) send_byte(quoted_char());
        send_byte(CH_QUOTE);
      end
    end
    if ($urandom_range(3) == 0) send_byte(blank_char());
    if ($urandom_range(2) == 0) send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic send_sub_block();
    send_byte(CH_OPEN);
    send_byte(CH_LF);
    repeat ($urandom_range(3, 1)) send_record(1'b1);
    send_byte(CH_CLOSE);
    send_byte(CH_LF);
  endtask

  // Broken lines: bad line start, bad label character, cut-off quote, lone closing brace
  task automatic send_broken();
    case ($urandom_range(3))
      0: begin
        send_byte(8'($urandom_range(255)));
        send_byte(CH_LF);
      end
      1: begin
        send_byte(CH_HASH);
        repeat ($urandom_range(3)) send_byte(8'(CH_A + $urandom_range(25)));
        send_byte($urandom_range(1) ? 8'(CH_LOWER_A + $urandom_range(25))
                                    : 8'(CH_DIGIT_0 + $urandom_range(9)));
      end
      2: begin
        send_text("#T ");
        send_byte(CH_QUOTE);
        repeat ($urandom_range(4)) send_byte(quoted_char());
      end
      default: begin
        send_byte(CH_CLOSE);
      end
    endcase
    resync_line();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
    resync_line();
  endtask

  // A fixed sequence of phase transitions and special cases
  task automatic test_directed_cases();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_byte(CH_LF);
    send_byte(8'hFF);
    send_byte(CH_CLOSE);
    send_text("#Ab");
    send_text("#K\n");
    send_text("#V");
    send_byte(CH_CR);
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(8'hFF);
    send_byte(CH_LF);
    send_byte(CH_QUOTE);
    send_byte(8'h00);
    send_byte(CH_CR);
    send_byte(CH_TAB);
    send_byte(CH_LF);
    send_byte(CH_OPEN);
    send_byte(CH_TAB);
    send_byte(CH_OPEN);
    send_byte(CH_CLOSE);
    wait_drained();
  endtask

  // Mostly well-formed records, the rest broken lines and noise
  task automatic test_random_traffic(input int n_bytes, input int tx_pct, input int rx_pct);
    int stop_at;
    int pick;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 60) send_record(1'b0);
      else if (pick < 78) send_sub_block();
      else if (pick < 90) send_broken();
      else send_noise();
    end
    wait_drained();
  endtask

  // Hold the result side long enough that the block stalls its input
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    repeat (4) send_record(1'b0);
    wait_drained();
  endtask

  // Drain the block in the middle of a record; the parse state must survive
  task automatic test_pause_mid_record();
    tx_idle_pct = 0;
    rx_idle_pct = 20;
    send_text("#PAUSE ");
    send_byte(CH_QUOTE);
    send_text("ab");
    wait_drained();
    send_byte(CH_QUOTE);
    send_text(" v");
    wait_drained();
    send_byte(CH_LF);
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte_in = 8'h00;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_random_traffic(270, 28, 51);
    test_random_traffic(270, 51, 28);
    test_output_backpressure();
    test_pause_mid_record();
    test_random_traffic(230, 0, 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    mismatch_count += flagged_bytes_q.size();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
